@@ rtl/core/spectral_peak_track_features_assert.svh @@
// Assertion macros used by the spectral peak tracker RTL
`ifndef SPECTRAL_PEAK_TRACK_FEATURES_ASSERT_SVH
`define SPECTRAL_PEAK_TRACK_FEATURES_ASSERT_SVH

// Check that cons holds in the same cycle as ante
`define SPTF_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("sptf assertion failed");

// Check that cons holds in the cycle after ante
`define SPTF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("sptf assertion failed");

`endif

@@ rtl/core/sptf_pkg.sv @@
// Constants and types for the spectral peak tracker
`default_nettype none

package sptf_pkg;

	localparam int unsigned HOP       = 32;
	localparam int unsigned MAX_BINS  = 256;

	localparam int unsigned BIN_W     = $clog2(MAX_BINS);
	localparam int unsigned CNT_W     = $clog2(MAX_BINS + 1);
	localparam int unsigned MAG_W     = 32;
	localparam int unsigned FREQ_W    = 24;
	localparam int unsigned POS_W     = 32;
	localparam int unsigned FRAME_W   = 27;
	localparam int unsigned BWID_W    = 16;
	localparam int unsigned SCNT_W    = 32;
	localparam int unsigned CFG_W     = 32;
	localparam int unsigned CFG_IDX_W = 1;

	// product of bin number and bin width, at least one bit above a frequency
	localparam int unsigned PROD_W =
		(BIN_W + BWID_W > FREQ_W) ? (BIN_W + BWID_W) : (FREQ_W + 1);

	localparam logic [FREQ_W-1:0] FREQ_MAX   = {FREQ_W{1'b1}};
	localparam logic [FREQ_W-1:0] STEP_RESET = FREQ_W'(1000000);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BIN_WIDTH    = 1'b0,
		REG_SAMPLE_COUNT = 1'b1
	} reg_idx_t;

endpackage

`default_nettype wire

@@ rtl/core/spectral_peak_track_features.sv @@
// Spectral peak tracker: per-frame peak bin and running call features
//
//  channel | direction | handshake           | payload
//  in      | sink      | in_valid / in_stall | magnitude, last_bin, new_call
//  out     | source    | out_valid/out_stall | peak_freq ... centre_valid
//  cfg     | sink      | cfg_we              | cfg_index, cfg_data
//
// One bin is accepted per cycle while in_stall is low; three register stages
// (input, peak bin, frame frequency) lead to the feature update and the result
// register, so a frame's result is registered after its last bin passes them.
// Reset clears all control, configuration and running feature state.
// A held result stalls the frame-end feature stage and the full stages behind
// it; bins that end no frame keep flowing into the empty stages.
`default_nettype none

module spectral_peak_track_features (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	output logic                                     in_stall,
	input  wire logic [sptf_pkg::MAG_W-1:0]          magnitude,
	input  wire logic                                last_bin,
	input  wire logic                                new_call,
	output logic                                     out_valid,
	input  wire logic                                out_stall,
	output logic [sptf_pkg::FREQ_W-1:0]              peak_freq,
	output logic [sptf_pkg::POS_W-1:0]               frame_pos,
	output logic [sptf_pkg::FREQ_W-1:0]              max_freq,
	output logic [sptf_pkg::POS_W-1:0]               max_freq_pos,
	output logic [sptf_pkg::FREQ_W-1:0]              min_freq,
	output logic [sptf_pkg::POS_W-1:0]               min_freq_pos,
	output logic [sptf_pkg::FREQ_W-1:0]              bandwidth,
	output logic [sptf_pkg::FREQ_W-1:0]              char_freq,
	output logic [sptf_pkg::FREQ_W-1:0]              centre_freq,
	output logic                                     centre_valid,
	input  wire logic                                cfg_we,
	input  wire logic [sptf_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [sptf_pkg::CFG_W-1:0]          cfg_data
);

	`include "spectral_peak_track_features_assert.svh"

	// configuration
	logic [sptf_pkg::BWID_W-1:0] bin_width_q;
	logic [sptf_pkg::SCNT_W-1:0] sample_count_q;

	// stage 1: registered input transaction
	logic                        v_s1;
	logic [sptf_pkg::MAG_W-1:0]  mag_s1;
	logic                        last_s1;
	logic                        fresh_s1;

	// bin tracking state
	logic [sptf_pkg::CNT_W-1:0]  bin_cnt_q;
	logic [sptf_pkg::MAG_W-1:0]  best_mag_q;
	logic [sptf_pkg::BIN_W-1:0]  best_bin_q;

	// stage 2: peak bin so far in the frame
	logic                        v_s2;
	logic [sptf_pkg::BIN_W-1:0]  bin_s2;
	logic                        last_s2;
	logic                        fresh_s2;

	// stage 3: frame frequency
	logic                        v_s3;
	logic [sptf_pkg::FREQ_W-1:0] freq_s3;
	logic                        last_s3;
	logic                        fresh_s3;

	// running feature state
	logic [sptf_pkg::FRAME_W-1:0] frame_q;
	logic [sptf_pkg::FREQ_W-1:0]  max_seen_q;
	logic [sptf_pkg::POS_W-1:0]   max_pos_q;
	logic [sptf_pkg::FREQ_W-1:0]  min_seen_q;
	logic [sptf_pkg::POS_W-1:0]   min_pos_q;
	logic [sptf_pkg::FREQ_W-1:0]  prev_freq_q;
	logic [sptf_pkg::FREQ_W-1:0]  least_step_q;
	logic [sptf_pkg::FREQ_W-1:0]  char_held_q;
	logic [sptf_pkg::FREQ_W-1:0]  centre_held_q;
	logic                         centre_done_q;

	// result register
	logic                         out_valid_q;
	logic [sptf_pkg::FREQ_W-1:0]  peak_freq_q;
	logic [sptf_pkg::POS_W-1:0]   frame_pos_q;
	logic [sptf_pkg::FREQ_W-1:0]  max_freq_q;
	logic [sptf_pkg::POS_W-1:0]   max_freq_pos_q;
	logic [sptf_pkg::FREQ_W-1:0]  min_freq_q;
	logic [sptf_pkg::POS_W-1:0]   min_freq_pos_q;
	logic [sptf_pkg::FREQ_W-1:0]  bandwidth_q;
	logic [sptf_pkg::FREQ_W-1:0]  char_freq_q;
	logic [sptf_pkg::FREQ_W-1:0]  centre_freq_q;
	logic                         centre_valid_q;

	// flow control
	logic out_ready;
	logic en3;
	logic en2;
	logic en1;
	logic fire1;
	logic fire3;

	// a non-final bin leaves stage 3 without needing the result register
	assign out_ready = !out_valid_q || !out_stall;
	assign en3       = !v_s3 || !last_s3 || out_ready;
	assign en2       = !v_s2 || en3;
	assign en1       = !v_s1 || en2;
	assign in_stall  = !en1;
	assign fire1     = v_s1 && en2;
	assign fire3     = v_s3 && en3;

	// write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bin_width_q    <= '0;
			sample_count_q <= '0;
		end else if (cfg_we) begin
			unique case (sptf_pkg::reg_idx_t'(cfg_index))
				sptf_pkg::REG_BIN_WIDTH:    bin_width_q    <= cfg_data[sptf_pkg::BWID_W-1:0];
				sptf_pkg::REG_SAMPLE_COUNT: sample_count_q <= cfg_data[sptf_pkg::SCNT_W-1:0];
			endcase
		end
	end

	// capture the input transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en1) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en1 && in_valid) begin
			mag_s1   <= magnitude;
			last_s1  <= last_bin;
			fresh_s1 <= new_call;
		end
	end

	// track the first strictly largest bin of the frame
	logic [sptf_pkg::CNT_W-1:0] cnt_eff;
	logic [sptf_pkg::MAG_W-1:0] best_mag_eff;
	logic [sptf_pkg::BIN_W-1:0] best_bin_eff;
	logic [sptf_pkg::CNT_W-1:0] cnt_nx;
	logic [sptf_pkg::MAG_W-1:0] best_mag_nx;
	logic [sptf_pkg::BIN_W-1:0] best_bin_nx;

	always_comb begin
		cnt_eff      = fresh_s1 ? '0 : bin_cnt_q;
		best_mag_eff = fresh_s1 ? '0 : best_mag_q;
		best_bin_eff = fresh_s1 ? '0 : best_bin_q;
		cnt_nx       = cnt_eff;
		best_mag_nx  = best_mag_eff;
		best_bin_nx  = best_bin_eff;
		if (cnt_eff < sptf_pkg::CNT_W'(sptf_pkg::MAX_BINS)) begin
			if (mag_s1 > best_mag_eff) begin
				best_mag_nx = mag_s1;
				best_bin_nx = cnt_eff[sptf_pkg::BIN_W-1:0];
			end
			cnt_nx = cnt_eff + sptf_pkg::CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bin_cnt_q  <= '0;
			best_mag_q <= '0;
			best_bin_q <= '0;
		end else if (fire1) begin
			if (last_s1) begin
				bin_cnt_q  <= '0;
				best_mag_q <= '0;
				best_bin_q <= '0;
			end else begin
				bin_cnt_q  <= cnt_nx;
				best_mag_q <= best_mag_nx;
				best_bin_q <= best_bin_nx;
			end
		end
	end

	// advance to the multiply stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire1) begin
			bin_s2   <= best_bin_nx;
			last_s2  <= last_s1;
			fresh_s2 <= fresh_s1;
		end
	end

	// form the peak frequency, saturated to the field width
	logic [sptf_pkg::PROD_W-1:0] prod;
	logic [sptf_pkg::FREQ_W-1:0] freq_nx;

	always_comb begin
		prod    = sptf_pkg::PROD_W'(bin_s2) * sptf_pkg::PROD_W'(bin_width_q);
		freq_nx = (prod > sptf_pkg::PROD_W'(sptf_pkg::FREQ_MAX)) ?
			sptf_pkg::FREQ_MAX : prod[sptf_pkg::FREQ_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en3) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s2 && en3) begin
			freq_s3  <= freq_nx;
			last_s3  <= last_s2;
			fresh_s3 <= fresh_s2;
		end
	end

	// update the call features at frame end
	logic [sptf_pkg::FRAME_W-1:0] frame_eff;
	logic [sptf_pkg::FREQ_W-1:0]  max_eff;
	logic [sptf_pkg::POS_W-1:0]   max_pos_eff;
	logic [sptf_pkg::FREQ_W-1:0]  min_eff;
	logic [sptf_pkg::POS_W-1:0]   min_pos_eff;
	logic [sptf_pkg::FREQ_W-1:0]  prev_eff;
	logic [sptf_pkg::FREQ_W-1:0]  least_eff;
	logic [sptf_pkg::FREQ_W-1:0]  char_eff;
	logic [sptf_pkg::FREQ_W-1:0]  centre_eff;
	logic                         done_eff;
	logic [63:0]                  pos_full;
	logic [sptf_pkg::POS_W-1:0]   pos;
	logic [sptf_pkg::POS_W+2:0]   pos_x5;
	logic [sptf_pkg::POS_W+2:0]   scnt_x3;
	logic [sptf_pkg::POS_W:0]     pos_x2;
	logic [sptf_pkg::FREQ_W-1:0]  step;
	logic [sptf_pkg::FRAME_W-1:0] frame_nx;
	logic [sptf_pkg::FREQ_W-1:0]  max_nx;
	logic [sptf_pkg::POS_W-1:0]   max_pos_nx;
	logic [sptf_pkg::FREQ_W-1:0]  min_nx;
	logic [sptf_pkg::POS_W-1:0]   min_pos_nx;
	logic [sptf_pkg::FREQ_W-1:0]  prev_nx;
	logic [sptf_pkg::FREQ_W-1:0]  least_nx;
	logic [sptf_pkg::FREQ_W-1:0]  char_nx;
	logic [sptf_pkg::FREQ_W-1:0]  centre_nx;
	logic                         done_nx;
	logic [sptf_pkg::FREQ_W-1:0]  bw_nx;

	always_comb begin
		// a new call clears the running features before this transaction
		frame_eff   = fresh_s3 ? '0 : frame_q;
		max_eff     = fresh_s3 ? '0 : max_seen_q;
		max_pos_eff = fresh_s3 ? '0 : max_pos_q;
		min_eff     = fresh_s3 ? sptf_pkg::FREQ_MAX : min_seen_q;
		min_pos_eff = fresh_s3 ? '0 : min_pos_q;
		prev_eff    = fresh_s3 ? '0 : prev_freq_q;
		least_eff   = fresh_s3 ? sptf_pkg::STEP_RESET : least_step_q;
		char_eff    = fresh_s3 ? '0 : char_held_q;
		centre_eff  = fresh_s3 ? '0 : centre_held_q;
		done_eff    = fresh_s3 ? 1'b0 : centre_done_q;

		pos_full = 64'(frame_eff) * 64'(sptf_pkg::HOP);
		pos      = pos_full[sptf_pkg::POS_W-1:0];
		pos_x5   = (sptf_pkg::POS_W+3)'(pos) + (sptf_pkg::POS_W+3)'({pos, 2'b00});
		scnt_x3  = (sptf_pkg::POS_W+3)'(sample_count_q)
			+ (sptf_pkg::POS_W+3)'({sample_count_q, 1'b0});
		pos_x2   = {pos, 1'b0};
		step     = (freq_s3 >= prev_eff) ? (freq_s3 - prev_eff) : (prev_eff - freq_s3);

		frame_nx   = frame_eff;
		max_nx     = max_eff;
		max_pos_nx = max_pos_eff;
		min_nx     = min_eff;
		min_pos_nx = min_pos_eff;
		prev_nx    = prev_eff;
		least_nx   = least_eff;
		char_nx    = char_eff;
		centre_nx  = centre_eff;
		done_nx    = done_eff;

		if (last_s3) begin
			frame_nx = frame_eff + sptf_pkg::FRAME_W'(1);
			if (freq_s3 > max_eff) begin
				max_nx     = freq_s3;
				max_pos_nx = pos;
			end
			if (freq_s3 < min_eff) begin
				min_nx     = freq_s3;
				min_pos_nx = pos;
			end
			// least step after the sixty percent point
			if (pos_x5 > scnt_x3 && step < least_eff) begin
				least_nx = step;
				char_nx  = freq_s3;
			end
			// centre is the frame before the first one past the half point
			if (!done_eff && pos_x2 > (sptf_pkg::POS_W+1)'(sample_count_q)) begin
				centre_nx = prev_eff;
				done_nx   = 1'b1;
			end
			prev_nx = freq_s3;
		end

		bw_nx = (max_nx >= min_nx) ? (max_nx - min_nx) : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_q       <= '0;
			max_seen_q    <= '0;
			max_pos_q     <= '0;
			min_seen_q    <= sptf_pkg::FREQ_MAX;
			min_pos_q     <= '0;
			prev_freq_q   <= '0;
			least_step_q  <= sptf_pkg::STEP_RESET;
			char_held_q   <= '0;
			centre_held_q <= '0;
			centre_done_q <= 1'b0;
		end else if (fire3) begin
			frame_q       <= frame_nx;
			max_seen_q    <= max_nx;
			max_pos_q     <= max_pos_nx;
			min_seen_q    <= min_nx;
			min_pos_q     <= min_pos_nx;
			prev_freq_q   <= prev_nx;
			least_step_q  <= least_nx;
			char_held_q   <= char_nx;
			centre_held_q <= centre_nx;
			centre_done_q <= done_nx;
		end
	end

	// load the result register, hold it while stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_ready) begin
			out_valid_q <= fire3 && last_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (fire3 && last_s3) begin
			peak_freq_q    <= freq_s3;
			frame_pos_q    <= pos;
			max_freq_q     <= max_nx;
			max_freq_pos_q <= max_pos_nx;
			min_freq_q     <= min_nx;
			min_freq_pos_q <= min_pos_nx;
			bandwidth_q    <= bw_nx;
			char_freq_q    <= char_nx;
			centre_freq_q  <= centre_nx;
			centre_valid_q <= done_nx;
		end
	end

	assign out_valid    = out_valid_q;
	assign peak_freq    = peak_freq_q;
	assign frame_pos    = frame_pos_q;
	assign max_freq     = max_freq_q;
	assign max_freq_pos = max_freq_pos_q;
	assign min_freq     = min_freq_q;
	assign min_freq_pos = min_freq_pos_q;
	assign bandwidth    = bandwidth_q;
	assign char_freq    = char_freq_q;
	assign centre_freq  = centre_freq_q;
	assign centre_valid = centre_valid_q;

	// a frame's result always has min at or below max
	`SPTF_ASSERT_NOW(a_min_le_max, clk, arst_n, out_valid_q, min_freq_q <= max_freq_q)
	// centre stays zero until it is found
	`SPTF_ASSERT_NOW(a_centre_zero, clk, arst_n, out_valid_q && !centre_valid_q, centre_freq_q == '0)
	// the bin counter saturates at the frame size limit
	`SPTF_ASSERT_NOW(a_bin_cnt_max, clk, arst_n, 1'b1, bin_cnt_q <= sptf_pkg::CNT_W'(sptf_pkg::MAX_BINS))
	// input stalls only with held transactions in stages one and two
	`SPTF_ASSERT_NOW(a_stall_full, clk, arst_n, in_stall, v_s1 && v_s2)
	// a held characteristic frequency implies a step below the reset value
	`SPTF_ASSERT_NOW(a_char_step, clk, arst_n, char_held_q != '0, least_step_q < sptf_pkg::STEP_RESET)

endmodule

`default_nettype wire

@@ verif/tb_spectral_peak_track_features.sv @@
// Testbench for the spectral peak tracker: frame stimulus, feature prediction and result checks
`timescale 1ns / 1ps

typedef struct {
	logic [sptf_pkg::FREQ_W-1:0] peak_freq;
	logic [sptf_pkg::POS_W-1:0]  frame_pos;
	logic [sptf_pkg::FREQ_W-1:0] max_freq;
	logic [sptf_pkg::POS_W-1:0]  max_freq_pos;
	logic [sptf_pkg::FREQ_W-1:0] min_freq;
	logic [sptf_pkg::POS_W-1:0]  min_freq_pos;
	logic [sptf_pkg::FREQ_W-1:0] bandwidth;
	logic [sptf_pkg::FREQ_W-1:0] char_freq;
	logic [sptf_pkg::FREQ_W-1:0] centre_freq;
	logic                        centre_valid;
} frame_features_t;

typedef logic [31:0] feature_words_t [10];

// Running call features of the tracker and the frame results still owed by the block
class call_feature_tracker;
	logic [sptf_pkg::BWID_W-1:0]  bin_width;
	logic [sptf_pkg::SCNT_W-1:0]  sample_count;

	int unsigned                  bin_count;
	logic [sptf_pkg::MAG_W-1:0]   best_mag;
	logic [sptf_pkg::BIN_W-1:0]   best_bin;
	logic [sptf_pkg::FRAME_W-1:0] frame_idx;
	logic [sptf_pkg::FREQ_W-1:0]  max_f;
	logic [sptf_pkg::POS_W-1:0]   max_p;
	logic [sptf_pkg::FREQ_W-1:0]  min_f;
	logic [sptf_pkg::POS_W-1:0]   min_p;
	logic [sptf_pkg::FREQ_W-1:0]  prev_f;
	logic [sptf_pkg::FREQ_W-1:0]  least_step;
	logic [sptf_pkg::FREQ_W-1:0]  char_f;
	logic [sptf_pkg::FREQ_W-1:0]  centre_f;
	logic                         centre_found;

	frame_features_t    owed_frames [$];
	int unsigned        errors;
	string field_name [10] = '{"peak_freq", "frame_pos", "max_freq", "max_freq_pos",
		"min_freq", "min_freq_pos", "bandwidth", "char_freq", "centre_freq", "centre_valid"};

	function new();
		bin_width = '0;
		sample_count = '0;
		errors = 0;
		clear_call();
	endfunction

	function void clear_call();
		bin_count = 0;
		best_mag = '0;
		best_bin = '0;
		frame_idx = '0;
		max_f = '0;
		max_p = '0;
		min_f = sptf_pkg::FREQ_MAX;
		min_p = '0;
		prev_f = '0;
		least_step = sptf_pkg::STEP_RESET;
		char_f = '0;
		centre_f = '0;
		centre_found = 1'b0;
	endfunction

	function void set_reg(sptf_pkg::reg_idx_t idx, logic [sptf_pkg::CFG_W-1:0] value);
		case (idx)
			sptf_pkg::REG_BIN_WIDTH: bin_width = value[sptf_pkg::BWID_W-1:0];
			sptf_pkg::REG_SAMPLE_COUNT: sample_count = value[sptf_pkg::SCNT_W-1:0];
			default: ;
		endcase
	endfunction

	// Track the peak bin; at a frame end update the features and owe one result
	function void take_bin(logic [sptf_pkg::MAG_W-1:0] mag, bit last, bit fresh);
		logic [63:0]                 prod;
		logic [63:0]                 pos_wide;
		logic [sptf_pkg::FREQ_W-1:0] freq;
		logic [sptf_pkg::FREQ_W-1:0] step;
		logic [sptf_pkg::POS_W-1:0]  pos;
		frame_features_t             want;

		if (fresh)
			clear_call();
		if (bin_count < sptf_pkg::MAX_BINS) begin
			if (mag > best_mag) begin
				best_mag = mag;
				best_bin = sptf_pkg::BIN_W'(bin_count);
			end
			bin_count++;
		end
		if (!last)
			return;

		prod = 64'(best_bin) * 64'(bin_width);
		freq = (prod > 64'(sptf_pkg::FREQ_MAX)) ? sptf_pkg::FREQ_MAX
			: prod[sptf_pkg::FREQ_W-1:0];
		pos_wide = 64'(frame_idx) * 64'(sptf_pkg::HOP);
		pos = pos_wide[sptf_pkg::POS_W-1:0];

		if (freq > max_f) begin
			max_f = freq;
			max_p = pos;
		end
		if (freq < min_f) begin
			min_f = freq;
			min_p = pos;
		end
		// least step past the sixty percent point
		if (64'(pos) * 5 > 64'(sample_count) * 3) begin
			step = (freq >= prev_f) ? freq - prev_f : prev_f - freq;
			if (step < least_step) begin
				least_step = step;
				char_f = freq;
			end
		end
		// latch the previous frame once the half point is passed
		if (!centre_found && 64'(pos) * 2 > 64'(sample_count)) begin
			centre_f = prev_f;
			centre_found = 1'b1;
		end
		prev_f = freq;

		want.peak_freq = freq;
		want.frame_pos = pos;
		want.max_freq = max_f;
		want.max_freq_pos = max_p;
		want.min_freq = min_f;
		want.min_freq_pos = min_p;
		want.bandwidth = (max_f >= min_f) ? max_f - min_f : '0;
		want.char_freq = char_f;
		want.centre_freq = centre_f;
		want.centre_valid = centre_found;
		owed_frames.insert(owed_frames.size(), want);

		frame_idx = frame_idx + 1'b1;
		bin_count = 0;
		best_mag = '0;
		best_bin = '0;
	endfunction

	function feature_words_t flatten(frame_features_t f);
		feature_words_t w;
		w = '{32'(f.peak_freq), f.frame_pos, 32'(f.max_freq), f.max_freq_pos,
			32'(f.min_freq), f.min_freq_pos, 32'(f.bandwidth), 32'(f.char_freq),
			32'(f.centre_freq), 32'(f.centre_valid)};
		return w;
	endfunction

	// Compare one result transaction with the oldest owed frame
	function void match_frame(frame_features_t got);
		feature_words_t want_w;
		feature_words_t got_w;

		if (owed_frames.size() == 0) begin
			errors++;
			if (errors <= 10)
				$display("[%0t] unexpected result: peak_freq %0d frame_pos %0d",
					$time, got.peak_freq, got.frame_pos);
			return;
		end
		want_w = flatten(owed_frames.pop_front());
		got_w = flatten(got);
		for (int i = 0; i < 10; i++) begin
			if (got_w[i] !== want_w[i]) begin
				errors++;
				if (errors <= 10)
					$display("[%0t] %s mismatch: expected %0d (0x%0h) actual %0d (0x%0h)",
						$time, field_name[i], want_w[i], want_w[i], got_w[i], got_w[i]);
			end
		end
	endfunction
endclass

module tb_spectral_peak_track_features;

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           in_valid = 1'b0;
	logic                           in_stall;
	logic [sptf_pkg::MAG_W-1:0]     magnitude = '0;
	logic                           last_bin = 1'b0;
	logic                           new_call = 1'b0;
	logic                           out_valid;
	logic                           out_stall = 1'b0;
	logic [sptf_pkg::FREQ_W-1:0]    peak_freq;
	logic [sptf_pkg::POS_W-1:0]     frame_pos;
	logic [sptf_pkg::FREQ_W-1:0]    max_freq;
	logic [sptf_pkg::POS_W-1:0]     max_freq_pos;
	logic [sptf_pkg::FREQ_W-1:0]    min_freq;
	logic [sptf_pkg::POS_W-1:0]     min_freq_pos;
	logic [sptf_pkg::FREQ_W-1:0]    bandwidth;
	logic [sptf_pkg::FREQ_W-1:0]    char_freq;
	logic [sptf_pkg::FREQ_W-1:0]    centre_freq;
	logic                           centre_valid;
	logic                           cfg_we = 1'b0;
	logic [sptf_pkg::CFG_IDX_W-1:0] cfg_index = sptf_pkg::REG_BIN_WIDTH;
	logic [sptf_pkg::CFG_W-1:0]     cfg_data = '0;

	call_feature_tracker tracker;
	frame_features_t     seen;
	int unsigned         burst_left = 0;
	int unsigned         rand_bins = 0;
	int unsigned         stall_tick = 0;
	int unsigned         stall_mode = 0;
	int unsigned         stall_run = 0;

	spectral_peak_track_features u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.magnitude    (magnitude),
		.last_bin     (last_bin),
		.new_call     (new_call),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.peak_freq    (peak_freq),
		.frame_pos    (frame_pos),
		.max_freq     (max_freq),
		.max_freq_pos (max_freq_pos),
		.min_freq     (min_freq),
		.min_freq_pos (min_freq_pos),
		.bandwidth    (bandwidth),
		.char_freq    (char_freq),
		.centre_freq  (centre_freq),
		.centre_valid (centre_valid),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// End the run if it hangs
	initial begin
		#1ms;
		$display("DONE: errors detected");
		$finish;
	end

	// Stall the result channel: open, random, or long runs, switching every so often
	always @(posedge clk) begin
		if (arst_n) begin
			stall_tick++;
			if (stall_tick % 160 == 0)
				stall_mode = $urandom_range(0, 2);
			case (stall_mode)
				0: out_stall <= 1'b0;
				1: out_stall <= ($urandom_range(0, 99) < 40);
				default: begin
					if (stall_run == 0) begin
						stall_run = $urandom_range(1, 24);
						out_stall <= !out_stall;
					end else begin
						stall_run--;
					end
				end
			endcase
		end
	end

	// Check each result transaction on the falling clock edge before the edge that takes it
	always @(negedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			seen.peak_freq = peak_freq;
			seen.frame_pos = frame_pos;
			seen.max_freq = max_freq;
			seen.max_freq_pos = max_freq_pos;
			seen.min_freq = min_freq;
			seen.min_freq_pos = min_freq_pos;
			seen.bandwidth = bandwidth;
			seen.char_freq = char_freq;
			seen.centre_freq = centre_freq;
			seen.centre_valid = centre_valid;
			tracker.match_frame(seen);
		end
	end

	function automatic logic [sptf_pkg::MAG_W-1:0] pick_magnitude();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return 32'hFFFF_FFFF;
			2: return $urandom_range(0, 3);
			default: return $urandom();
		endcase
	endfunction

	// Send one bin transaction in bursts with random gaps between them
	task automatic send_bin(input logic [sptf_pkg::MAG_W-1:0] mag, input bit last,
		input bit fresh);
		bit taken;
		int unsigned gap;

		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		burst_left--;
		in_valid <= 1'b1;
		magnitude <= mag;
		last_bin <= last;
		new_call <= fresh;
		do begin
			@(negedge clk);
			taken = !in_stall;
			@(posedge clk);
		end while (!taken);
		tracker.take_bin(mag, last, fresh);
	endtask

	// Hold the sender until every owed frame has come back, then let the pipe empty
	task automatic drain_frames();
		in_valid <= 1'b0;
		while (tracker.owed_frames.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(input sptf_pkg::reg_idx_t idx,
		input logic [sptf_pkg::CFG_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		tracker.set_reg(idx, value);
		@(posedge clk);
	endtask

	initial begin
		int unsigned phase;
		int unsigned phase_bins;
		int unsigned frames_left;
		int unsigned nbins;
		bit          call_start;
		bit          long_done;
		logic [sptf_pkg::BWID_W-1:0] bw;
		logic [sptf_pkg::SCNT_W-1:0] sc;

		tracker = new();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// widest bins, every frame after the first past both points
		write_reg(sptf_pkg::REG_BIN_WIDTH, 32'h0000_FFFF);
		write_reg(sptf_pkg::REG_SAMPLE_COUNT, 32'h0);
		send_bin(32'h0, 1'b1, 1'b1);
		send_bin(32'd5, 1'b0, 1'b0);
		send_bin(32'hFFFF_FFFF, 1'b0, 1'b0);
		send_bin(32'hFFFF_FFFF, 1'b0, 1'b0);
		send_bin(32'd7, 1'b1, 1'b0);
		send_bin(32'hFFFF_FFFF, 1'b1, 1'b0);
		// drop a partial frame on a new call
		send_bin(32'd3, 1'b0, 1'b0);
		send_bin(32'd9, 1'b0, 1'b0);
		send_bin(32'd4, 1'b0, 1'b1);
		send_bin(32'd2, 1'b0, 1'b0);
		send_bin(32'd8, 1'b1, 1'b0);
		drain_frames();

		// zero bin width, half point never reached
		write_reg(sptf_pkg::REG_BIN_WIDTH, 32'h0);
		write_reg(sptf_pkg::REG_SAMPLE_COUNT, 32'hFFFF_FFFF);
		send_bin(32'd1, 1'b0, 1'b1);
		send_bin(32'd2, 1'b1, 1'b0);
		send_bin(32'hFFFF_FFFF, 1'b1, 1'b0);
		drain_frames();

		// short call crossing the half and sixty percent points at the third frame
		write_reg(sptf_pkg::REG_BIN_WIDTH, 32'd1234);
		write_reg(sptf_pkg::REG_SAMPLE_COUNT, 32'd100);
		send_bin(32'd1, 1'b0, 1'b1);
		send_bin(32'd9, 1'b1, 1'b0);
		send_bin(32'd9, 1'b0, 1'b0);
		send_bin(32'd1, 1'b1, 1'b0);
		send_bin(32'd0, 1'b0, 1'b0);
		send_bin(32'd5, 1'b1, 1'b0);
		send_bin(32'd5, 1'b0, 1'b0);
		send_bin(32'd5, 1'b1, 1'b0);
		send_bin(32'd0, 1'b0, 1'b0);
		send_bin(32'd1, 1'b1, 1'b0);
		drain_frames();

		// random calls; each phase changes both registers once the block is idle
		phase = 0;
		frames_left = 0;
		long_done = 1'b0;
		while (rand_bins < 750) begin
			case (phase % 4)
				0: bw = 16'hFFFF;
				1: bw = '0;
				default: bw = 16'($urandom_range(1, 65535));
			endcase
			if (phase == 1)
				sc = '0;
			else if (phase == 3)
				sc = 32'hFFFF_FFFF;
			else
				sc = $urandom_range(0, 1500);
			write_reg(sptf_pkg::REG_BIN_WIDTH, 32'(bw));
			write_reg(sptf_pkg::REG_SAMPLE_COUNT, sc);

			phase_bins = 0;
			while (phase_bins < 125) begin
				call_start = 1'b0;
				if (frames_left == 0) begin
					frames_left = $urandom_range(1, 40);
					call_start = 1'b1;
				end
				frames_left--;
				// mostly short frames, now and then one past the bin limit
				if ((phase == 2 && !long_done) || $urandom_range(0, 199) == 0) begin
					nbins = $urandom_range(257, 300);
					long_done = 1'b1;
				end else begin
					nbins = $urandom_range(1, 12);
				end
				for (int unsigned b = 0; b < nbins; b++) begin
					send_bin((b >= 250 && $urandom_range(0, 1) == 1) ? 32'hFFFF_FFFF
						: pick_magnitude(), b == nbins - 1,
						(b == 0 && call_start) || $urandom_range(0, 99) == 0);
				end
				phase_bins += nbins;
				rand_bins += nbins;
			end
			drain_frames();
			phase++;
		end

		repeat (12) @(posedge clk);
		if (tracker.errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

@@ files.f @@
+incdir+rtl/core
rtl/core/sptf_pkg.sv
rtl/core/spectral_peak_track_features.sv
verif/tb_spectral_peak_track_features.sv
